// ===== rtl/core/dst_pkg.sv =====
package dst_pkg;

  localparam int MagBits     = 16;
  localparam int IntervalBits = 24;
  localparam int PosBits     = 32;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 24;

  typedef logic signed [MagBits-1:0]  mag_t;
  typedef logic [IntervalBits-1:0]    interval_t;
  typedef logic signed [PosBits-1:0]  pos_t;
  typedef logic [PosBits-1:0]         swing_t;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_TORQUE_MAGNITUDE    = 2'd0,
    REG_FLIP_INTERVAL_TICKS = 2'd1,
    REG_MEASURE_TICKS       = 2'd2
  } cfg_reg_t;

  localparam mag_t      MAG_RESET     = 16'sd40;
  localparam interval_t FLIP_RESET    = 24'd20;
  localparam interval_t MEASURE_RESET = 24'd6000;

  typedef struct packed {
    mag_t      torque_magnitude;
    interval_t flip_interval_ticks;
    interval_t measure_ticks;
  } cfg_t;

  typedef struct packed {
    logic start_measure;
    logic stop_request;
    logic feedback_ok;
    logic drive_enabled;
    pos_t position_sample;
  } tick_t;

  // Window control from the tick sequencer to the swing tracker.
  typedef struct packed {
    logic clear;
    logic sample;
    logic flip;
  } win_ctl_t;

endpackage

// ===== rtl/core/dst_cfg_regs.sv =====
module dst_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [dst_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [dst_pkg::CfgDataBits-1:0]    cfg_wdata,
  output dst_pkg::cfg_t                      cfg
);
  import dst_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.torque_magnitude    <= MAG_RESET;
      cfg_r.flip_interval_ticks <= FLIP_RESET;
      cfg_r.measure_ticks       <= MEASURE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TORQUE_MAGNITUDE:    cfg_r.torque_magnitude    <= mag_t'(cfg_wdata[MagBits-1:0]);
        REG_FLIP_INTERVAL_TICKS: cfg_r.flip_interval_ticks <= cfg_wdata[IntervalBits-1:0];
        REG_MEASURE_TICKS:       cfg_r.measure_ticks       <= cfg_wdata[IntervalBits-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/dst_swing_track.sv =====
module dst_swing_track (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  dst_pkg::win_ctl_t ctl,
  input  dst_pkg::pos_t     pos,
  output dst_pkg::swing_t   best_nxt
);
  import dst_pkg::*;

  logic   valid_r, valid_nxt;
  pos_t   low_r, low_nxt;
  pos_t   high_r, high_nxt;
  swing_t best_r;

  logic   v0, v1;
  pos_t   l0, h0, l1, h1;
  swing_t b0, swing;

  always_comb begin
    v0 = ctl.clear ? 1'b0 : valid_r;
    l0 = ctl.clear ? '0 : low_r;
    h0 = ctl.clear ? '0 : high_r;
    b0 = ctl.clear ? '0 : best_r;

    v1 = v0;
    l1 = l0;
    h1 = h0;
    if (ctl.sample) begin
      if (!v0) begin
        l1 = pos;
        h1 = pos;
        v1 = 1'b1;
      end else begin
        if (pos < l0) l1 = pos;
        if (pos > h0) h1 = pos;
      end
    end

    // The swing wraps to 32 bits, as the difference of two signed samples may.
    swing     = swing_t'(h1) - swing_t'(l1);
    valid_nxt = v1;
    low_nxt   = l1;
    high_nxt  = h1;
    best_nxt  = b0;
    if (ctl.flip && v1) begin
      if (swing > b0) best_nxt = swing;
      low_nxt  = pos;
      high_nxt = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      low_r   <= '0;
      high_r  <= '0;
      best_r  <= '0;
    end else if (step) begin
      valid_r <= valid_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      best_r  <= best_nxt;
    end
  end

endmodule

// ===== rtl/core/dst_tick_seq.sv =====
module dst_tick_seq #(
  parameter int TICK_COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  dst_pkg::cfg_t     cfg,
  input  dst_pkg::tick_t    tick,
  output dst_pkg::win_ctl_t ctl,
  output dst_pkg::mag_t     torque_nxt,
  output logic              done_nxt
);
  import dst_pkg::*;

  localparam int CW    = TICK_COUNT_BITS;
  localparam int CMP_W = (CW > IntervalBits) ? CW : IntervalBits;

  typedef logic [CW-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  logic   running_r, running_nxt;
  count_t elapsed_r, elapsed_nxt;
  count_t since_r, since_nxt;
  mag_t   drive_r, drive_nxt;
  mag_t   held_r;
  logic   done_r;

  logic   run, end_now, active, flip_due;
  count_t el0, sf0, sf1;
  mag_t   dl0, held0;
  logic   done0;

  always_comb begin
    run   = tick.start_measure | running_r;
    el0   = tick.start_measure ? '0 : elapsed_r;
    sf0   = tick.start_measure ? '0 : since_r;
    dl0   = tick.start_measure ? cfg.torque_magnitude : drive_r;
    held0 = tick.start_measure ? '0 : held_r;
    done0 = tick.start_measure ? 1'b0 : done_r;
    sf1   = sf0;

    end_now  = run && (tick.stop_request ||
               (CMP_W'(el0) >= CMP_W'(cfg.measure_ticks)));
    active   = run && !end_now;
    flip_due = CMP_W'(sf0) >= CMP_W'(cfg.flip_interval_ticks);

    ctl.clear  = tick.start_measure;
    ctl.sample = active && tick.feedback_ok && tick.drive_enabled;
    ctl.flip   = active && tick.feedback_ok && flip_due;

    running_nxt = run && !end_now;
    elapsed_nxt = el0;
    since_nxt   = sf0;
    drive_nxt   = dl0;
    torque_nxt  = held0;
    done_nxt    = done0;

    if (end_now) begin
      torque_nxt = '0;
      done_nxt   = 1'b1;
    end else if (active) begin
      if (ctl.flip) begin
        drive_nxt = (dl0 > 0) ? -cfg.torque_magnitude : cfg.torque_magnitude;
        sf1       = '0;
      end
      if (tick.feedback_ok) torque_nxt = drive_nxt;
      elapsed_nxt = (el0 == COUNT_MAX) ? el0 : el0 + 1'b1;
      since_nxt   = (sf1 == COUNT_MAX) ? sf1 : sf1 + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      elapsed_r <= '0;
      since_r   <= '0;
      drive_r   <= '0;
      held_r    <= '0;
      done_r    <= 1'b0;
    end else if (step) begin
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
      since_r   <= since_nxt;
      drive_r   <= drive_nxt;
      held_r    <= torque_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

// ===== rtl/core/dither_swing_tracker.sv =====
// An input transfer enters the tick register; its result goes to the result
// register. One tick per cycle unless out_stall holds the result register: the
// tick register feeds one pass of counters, compares and a 32-bit subtraction.
// Reset (rst_n low, synchronous) returns the registers to their defaults, stops
// any measurement and empties both pipeline registers.
module dither_swing_tracker #(
  parameter int TICK_COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_wr_en,
  input  logic [dst_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [dst_pkg::CfgDataBits-1:0] cfg_wdata,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_start_measure,
  input  logic                            in_stop_request,
  input  logic                            in_feedback_ok,
  input  logic                            in_drive_enabled,
  input  logic signed [31:0]              in_position_sample,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              out_torque_command,
  output logic [31:0]                     out_largest_swing,
  output logic                            out_finished
);
  import dst_pkg::*;

  cfg_t     cfg;
  tick_t    tick_r;
  logic     tick_valid_r;
  logic     step;
  win_ctl_t ctl;
  mag_t     torque_nxt;
  logic     done_nxt;
  swing_t   best_nxt;

  logic     out_valid_r;
  mag_t     out_torque_r;
  swing_t   out_swing_r;
  logic     out_done_r;

  // A tick is processed when the result register is free or being drained.
  assign step     = tick_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = tick_valid_r && !step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (!in_stall) begin
      tick_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      tick_r.start_measure   <= in_start_measure;
      tick_r.stop_request    <= in_stop_request;
      tick_r.feedback_ok     <= in_feedback_ok;
      tick_r.drive_enabled   <= in_drive_enabled;
      tick_r.position_sample <= in_position_sample;
    end
  end

  dst_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dst_tick_seq #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cfg        (cfg),
    .tick       (tick_r),
    .ctl        (ctl),
    .torque_nxt (torque_nxt),
    .done_nxt   (done_nxt)
  );

  dst_swing_track u_swing (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .ctl      (ctl),
    .pos      (tick_r.position_sample),
    .best_nxt (best_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_torque_r <= torque_nxt;
      out_swing_r  <= best_nxt;
      out_done_r   <= done_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_torque_command = out_torque_r;
  assign out_largest_swing  = out_swing_r;
  assign out_finished       = out_done_r;

endmodule
